FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL. Under synthesis they expand
// to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PBA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define PBA_ASSERT(lbl, clk, rst, prop, msg)
`define PBA_ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif
`endif

FILE: hw/rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// Planar bearing angle package
// Widths, fixed-point constants, the arctangent table and the types that pass
// between the front end, the CORDIC pipeline and the rounding stages.
// ----------------------------------------------------------------------------
package pba_pkg;

  // Coordinate width and number of CORDIC iterations.
  localparam int COORD_BITS   = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int NSTEP        = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;

  // Input fields and coordinate differences.
  localparam int LON_W      = COORD_BITS;
  localparam int LAT_W      = COORD_BITS - 1;
  localparam int DLON_W     = LON_W + 1;
  localparam int DLAT_W     = LAT_W + 1;
  localparam int DX_W       = LON_W;
  localparam int DY_W       = LAT_W;
  localparam int IN_RAW_W   = 2 * LON_W + 2 * LAT_W;
  localparam int IN_TDATA_W = ((IN_RAW_W + 7) / 8) * 8;

  // Result field.
  localparam int MDEG_W      = 19;
  localparam int OUT_TDATA_W = ((MDEG_W + 7) / 8) * 8;

  // Normalisation: the larger difference is shifted up to bit NORM_POS.
  localparam int NORM_POS = 59;
  localparam int NORM_W   = NORM_POS + 1;
  localparam int SH_W     = 6;
  localparam int GRP_W    = 8;
  localparam int FINE_W   = 3;
  localparam int NGRP     = (DX_W + GRP_W - 1) / GRP_W;
  localparam int GALL_W   = NGRP * GRP_W;

  // CORDIC datapath, angles in units of 1e-9 degree.
  localparam int XY_W   = 63;
  localparam int Z_W    = 39;
  localparam int ATAN_W = 37;
  localparam int A_W    = 37;

  localparam logic [A_W-1:0] NDEG_90 = 37'd90000000000;

  localparam logic [ATAN_W-1:0] ATAN_NDEG [32] = '{
    37'd45000000000, 37'd26565051177, 37'd14036243468, 37'd7125016349,
    37'd3576334375,  37'd1789910608,  37'd895173710,   37'd447614171,
    37'd223810500,   37'd111905677,   37'd55952892,    37'd27976453,
    37'd13988227,    37'd6994114,     37'd3497057,     37'd1748528,
    37'd874264,      37'd437132,      37'd218566,      37'd109283,
    37'd54642,       37'd27321,       37'd13660,       37'd6830,
    37'd3415,        37'd1708,        37'd854,         37'd427,
    37'd213,         37'd107,         37'd53,          37'd27
  };

  // Quadrant fold with the half-millidegree rounding offset folded in.
  localparam int N_W = 39;
  localparam logic [N_W-1:0] OFS_EN = 39'd500000;
  localparam logic [N_W-1:0] OFS_ES = 39'd180000500000;
  localparam logic [N_W-1:0] OFS_WN = 39'd360000500000;
  localparam logic [N_W-1:0] OFS_WS = 39'd180000500000;

  // Division by 1e6 = 2^6 * 15625, the odd part by reciprocal and correction.
  localparam int PRE_SHIFT   = 6;
  localparam int NQ_W        = N_W - PRE_SHIFT;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 33;
  localparam int PROD_W      = NQ_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = 20'd549755;
  localparam int DIV_W = 14;
  localparam logic [DIV_W-1:0] DIV_LO = 14'd15625;
  localparam int R_W = 15;
  localparam logic [NQ_W-1:0] R_LIMIT = NQ_W'(2 * 15625);
  localparam logic [MDEG_W-1:0] FULL_MDEG = 19'd360000;

  typedef struct packed {
    logic east;
    logic north;
    logic dx_zero;
    logic dy_zero;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    side_t                  side;
  } cordic_t;

endpackage

FILE: hw/rtl/planar_bearing_angle.sv
// ----------------------------------------------------------------------------
// Planar bearing angle
// Bearing clockwise from north between two longitude/latitude points, in
// millidegrees, by a pipelined CORDIC arctangent and a quadrant fold.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | tdata fields (lowest bit first)
//   --------+-----------+----------------------------------------------------
//   s_*     | in        | from_lon[31:0], from_lat[62:32], to_lon[94:63],
//           |           | to_lat[125:95], zero padding [127:126]
//   m_*     | out       | bearing_mdeg[18:0], zero padding [23:19]
//
// One transaction is accepted per clock cycle when the pipeline is flowing.
// From acceptance to m_tvalid an item passes six front-end stages, one stage
// per CORDIC iteration and six rounding stages. Each stage holds its item on
// a stall and a stage that is empty takes a new item, so bubbles close up
// behind a stalled output.
// Reset clears only the valid bits; the data registers are not reset.
//
// Front end: A forms the signed differences, B takes their magnitudes and the
// quadrant flags, C1/C2 find the leading one of dx|dy a byte at a time, and
// D1/D2 shift both magnitudes so that the larger reaches bit 59 (coarse by
// whole bytes, then fine). The CORDIC then computes atan(dx/dy) in units of
// 1e-9 degree.
//
// Back end: E applies the clamp to [0, 90] degrees and the cases where one
// difference is zero, F folds the angle into its quadrant, adds half a
// millidegree and shifts by six, and G to J finish the division by one
// million: a multiply by the reciprocal of 15625 and a single correction
// step. A rounded full circle wraps to zero in J.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module planar_bearing_angle (
  input  logic                               clk,
  input  logic                               rst,
  // from_lon, from_lat, to_lon, to_lat, padding
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [pba_pkg::IN_TDATA_W-1:0]     s_tdata,
  // bearing_mdeg, padding
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [pba_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  localparam int LON_W       = pba_pkg::LON_W;
  localparam int LAT_W       = pba_pkg::LAT_W;
  localparam int DLON_W      = pba_pkg::DLON_W;
  localparam int DLAT_W      = pba_pkg::DLAT_W;
  localparam int DX_W        = pba_pkg::DX_W;
  localparam int DY_W        = pba_pkg::DY_W;
  localparam int NORM_POS    = pba_pkg::NORM_POS;
  localparam int NORM_W      = pba_pkg::NORM_W;
  localparam int SH_W        = pba_pkg::SH_W;
  localparam int GRP_W       = pba_pkg::GRP_W;
  localparam int FINE_W      = pba_pkg::FINE_W;
  localparam int NGRP        = pba_pkg::NGRP;
  localparam int GALL_W      = pba_pkg::GALL_W;
  localparam int XY_W        = pba_pkg::XY_W;
  localparam int Z_W         = pba_pkg::Z_W;
  localparam int A_W         = pba_pkg::A_W;
  localparam int N_W         = pba_pkg::N_W;
  localparam int PRE_SHIFT   = pba_pkg::PRE_SHIFT;
  localparam int NQ_W        = pba_pkg::NQ_W;
  localparam int RECIP_SHIFT = pba_pkg::RECIP_SHIFT;
  localparam int PROD_W      = pba_pkg::PROD_W;
  localparam int R_W         = pba_pkg::R_W;
  localparam int MDEG_W      = pba_pkg::MDEG_W;
  localparam int OUT_TDATA_W = pba_pkg::OUT_TDATA_W;

  // Input fields.
  logic [LON_W-1:0] from_lon;
  logic [LAT_W-1:0] from_lat;
  logic [LON_W-1:0] to_lon;
  logic [LAT_W-1:0] to_lat;

  assign from_lon = s_tdata[LON_W-1:0];
  assign from_lat = s_tdata[LON_W +: LAT_W];
  assign to_lon   = s_tdata[LON_W + LAT_W +: LON_W];
  assign to_lat   = s_tdata[2 * LON_W + LAT_W +: LAT_W];

  // Stage valid bits and advance enables.
  logic a_vld, b_vld, c1_vld, c2_vld, d1_vld, d2_vld;
  logic e_vld, f_vld, g_vld, h_vld, i_vld, j_vld;
  logic a_adv, b_adv, c1_adv, c2_adv, d1_adv, d2_adv;
  logic e_adv, f_adv, g_adv, h_adv, i_adv, j_adv;

  // Stage A: signed differences.
  logic [DLON_W-1:0] a_dlon, a_dlon_next;
  logic [DLAT_W-1:0] a_dlat, a_dlat_next;

  // Stage B: magnitudes and flags.
  logic [DLON_W-1:0]   b_neg_lon;
  logic [DLAT_W-1:0]   b_neg_lat;
  logic [DX_W-1:0]     b_dx, b_dx_next;
  logic [DX_W-1:0]     b_dy, b_dy_next;
  pba_pkg::side_t      b_side, b_side_next;

  // Stage C1: per-byte leading one.
  logic [GALL_W-1:0]             c1_w;
  logic [NGRP-1:0]               c1_any, c1_any_next;
  logic [NGRP-1:0][FINE_W-1:0]   c1_pos, c1_pos_next;
  logic [DX_W-1:0]               c1_dx, c1_dy;
  pba_pkg::side_t                c1_side;

  // Stage C2: shift amount.
  logic [SH_W-1:0]  c2_msb;
  logic [SH_W-1:0]  c2_sh, c2_sh_next;
  logic [DX_W-1:0]  c2_dx, c2_dy;
  pba_pkg::side_t   c2_side;

  // Stage D1: coarse shift.
  logic [NORM_W-1:0] d1_dx, d1_dx_next;
  logic [NORM_W-1:0] d1_dy, d1_dy_next;
  logic [FINE_W-1:0] d1_fine;
  pba_pkg::side_t    d1_side;

  // Stage D2: CORDIC start vector.
  pba_pkg::cordic_t  d2_data, d2_next;

  // CORDIC output.
  logic              c_in_ready;
  logic              c_out_valid;
  pba_pkg::cordic_t  c_out;

  // Back end.
  logic [A_W-1:0]      e_a, e_a_next;
  logic                e_east, e_north;
  logic [N_W-1:0]      f_ofs, f_n;
  logic                f_sub;
  logic [NQ_W-1:0]     f_nq;
  logic [PROD_W-1:0]   g_prod;
  logic [MDEG_W-1:0]   g_q0;
  logic [NQ_W-1:0]     g_nq;
  logic [NQ_W-1:0]     h_t, h_t_next;
  logic [MDEG_W-1:0]   h_q0;
  logic [NQ_W-1:0]     h_nq;
  logic [NQ_W-1:0]     i_r_next;
  logic                i_bump;
  logic [MDEG_W-1:0]   i_q0;
  logic [MDEG_W-1:0]   j_q;
  logic [MDEG_W-1:0]   j_mdeg, j_mdeg_next;

  // --------------------------------------------------------------------------
  // Flow control: a stage moves on when it is empty or its successor moves.
  // --------------------------------------------------------------------------
  assign j_adv  = !j_vld  || m_tready;
  assign i_adv  = !i_vld  || j_adv;
  assign h_adv  = !h_vld  || i_adv;
  assign g_adv  = !g_vld  || h_adv;
  assign f_adv  = !f_vld  || g_adv;
  assign e_adv  = !e_vld  || f_adv;
  assign d2_adv = !d2_vld || c_in_ready;
  assign d1_adv = !d1_vld || d2_adv;
  assign c2_adv = !c2_vld || d1_adv;
  assign c1_adv = !c1_vld || c2_adv;
  assign b_adv  = !b_vld  || c1_adv;
  assign a_adv  = !a_vld  || b_adv;

  assign s_tready = a_adv;
  assign m_tvalid = j_vld;
  assign m_tdata  = OUT_TDATA_W'(j_mdeg);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld  <= 1'b0;
      b_vld  <= 1'b0;
      c1_vld <= 1'b0;
      c2_vld <= 1'b0;
      d1_vld <= 1'b0;
      d2_vld <= 1'b0;
      e_vld  <= 1'b0;
      f_vld  <= 1'b0;
      g_vld  <= 1'b0;
      h_vld  <= 1'b0;
      i_vld  <= 1'b0;
      j_vld  <= 1'b0;
    end else begin
      if (a_adv)  a_vld  <= s_tvalid;
      if (b_adv)  b_vld  <= a_vld;
      if (c1_adv) c1_vld <= b_vld;
      if (c2_adv) c2_vld <= c1_vld;
      if (d1_adv) d1_vld <= c2_vld;
      if (d2_adv) d2_vld <= d1_vld;
      if (e_adv)  e_vld  <= c_out_valid;
      if (f_adv)  f_vld  <= e_vld;
      if (g_adv)  g_vld  <= f_vld;
      if (h_adv)  h_vld  <= g_vld;
      if (i_adv)  i_vld  <= h_vld;
      if (j_adv)  j_vld  <= i_vld;
    end
  end

  // --------------------------------------------------------------------------
  // Front end.
  // --------------------------------------------------------------------------
  // The differences are exact one bit wider than the operands.
  assign a_dlon_next = {to_lon[LON_W-1], to_lon} - {from_lon[LON_W-1], from_lon};
  assign a_dlat_next = {to_lat[LAT_W-1], to_lat} - {from_lat[LAT_W-1], from_lat};

  // A magnitude always fits one bit narrower than the difference.
  assign b_neg_lon = -a_dlon;
  assign b_neg_lat = -a_dlat;
  assign b_dx_next = a_dlon[DLON_W-1] ? b_neg_lon[DX_W-1:0] : a_dlon[DX_W-1:0];
  assign b_dy_next = DX_W'(a_dlat[DLAT_W-1] ? b_neg_lat[DY_W-1:0] : a_dlat[DY_W-1:0]);

  always_comb begin
    b_side_next.east    = !a_dlon[DLON_W-1];
    b_side_next.north   = !a_dlat[DLAT_W-1];
    b_side_next.dx_zero = (a_dlon == '0);
    b_side_next.dy_zero = (a_dlat == '0);
  end

  // The leading one of dx|dy is also that of the larger magnitude.
  assign c1_w = GALL_W'(b_dx | b_dy);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      c1_any_next[g] = |c1_w[g * GRP_W +: GRP_W];
      c1_pos_next[g] = '0;
      for (int b = 0; b < GRP_W; b++) begin
        if (c1_w[g * GRP_W + b]) begin
          c1_pos_next[g] = FINE_W'(b);
        end
      end
    end
  end

  always_comb begin
    c2_msb = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (c1_any[g]) begin
        c2_msb = SH_W'(g * GRP_W) + SH_W'(c1_pos[g]);
      end
    end
  end

  assign c2_sh_next = SH_W'(NORM_POS) - c2_msb;

  assign d1_dx_next = NORM_W'(c2_dx) << {c2_sh[SH_W-1:FINE_W], {FINE_W{1'b0}}};
  assign d1_dy_next = NORM_W'(c2_dy) << {c2_sh[SH_W-1:FINE_W], {FINE_W{1'b0}}};

  // The vector starts at (dy, dx), so the angle found is atan(dx/dy).
  always_comb begin
    d2_next.x    = XY_W'(d1_dy << d1_fine);
    d2_next.y    = XY_W'(d1_dx << d1_fine);
    d2_next.z    = '0;
    d2_next.side = d1_side;
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      a_dlon <= a_dlon_next;
      a_dlat <= a_dlat_next;
    end
    if (b_adv) begin
      b_dx   <= b_dx_next;
      b_dy   <= b_dy_next;
      b_side <= b_side_next;
    end
    if (c1_adv) begin
      c1_any  <= c1_any_next;
      c1_pos  <= c1_pos_next;
      c1_dx   <= b_dx;
      c1_dy   <= b_dy;
      c1_side <= b_side;
    end
    if (c2_adv) begin
      c2_sh   <= c2_sh_next;
      c2_dx   <= c1_dx;
      c2_dy   <= c1_dy;
      c2_side <= c1_side;
    end
    if (d1_adv) begin
      d1_dx   <= d1_dx_next;
      d1_dy   <= d1_dy_next;
      d1_fine <= c2_sh[FINE_W-1:0];
      d1_side <= c2_side;
    end
    if (d2_adv) begin
      d2_data <= d2_next;
    end
  end

  pba_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_vld),
    .in_ready  (c_in_ready),
    .in_data   (d2_data),
    .out_valid (c_out_valid),
    .out_ready (e_adv),
    .out_data  (c_out)
  );

  // --------------------------------------------------------------------------
  // Back end.
  // --------------------------------------------------------------------------
  // A zero east-west difference gives due north or south even when both are
  // zero; a zero north-south difference alone gives exactly 90 degrees.
  always_comb begin
    if (c_out.side.dx_zero) begin
      e_a_next = '0;
    end else if (c_out.side.dy_zero) begin
      e_a_next = pba_pkg::NDEG_90;
    end else if (c_out.z[Z_W-1]) begin
      e_a_next = '0;
    end else if (c_out.z > $signed({{(Z_W - A_W){1'b0}}, pba_pkg::NDEG_90})) begin
      e_a_next = pba_pkg::NDEG_90;
    end else begin
      e_a_next = c_out.z[A_W-1:0];
    end
  end

  always_comb begin
    case ({e_east, e_north})
      2'b11:   begin f_ofs = pba_pkg::OFS_EN; f_sub = 1'b0; end
      2'b10:   begin f_ofs = pba_pkg::OFS_ES; f_sub = 1'b1; end
      2'b01:   begin f_ofs = pba_pkg::OFS_WN; f_sub = 1'b1; end
      default: begin f_ofs = pba_pkg::OFS_WS; f_sub = 1'b0; end
    endcase
  end

  assign f_n = f_sub ? (f_ofs - N_W'(e_a)) : (f_ofs + N_W'(e_a));

  // The reciprocal estimate is at most one below the true quotient.
  assign g_prod   = PROD_W'(f_nq) * PROD_W'(pba_pkg::RECIP);
  assign h_t_next = NQ_W'(g_q0) * NQ_W'(pba_pkg::DIV_LO);
  assign i_r_next = h_nq - h_t;
  assign j_q      = i_q0 + MDEG_W'(i_bump);
  assign j_mdeg_next = (j_q == pba_pkg::FULL_MDEG) ? '0 : j_q;

  always_ff @(posedge clk) begin
    if (e_adv) begin
      e_a     <= e_a_next;
      e_east  <= c_out.side.east;
      e_north <= c_out.side.north;
    end
    if (f_adv) begin
      f_nq <= f_n[N_W-1:PRE_SHIFT];
    end
    if (g_adv) begin
      g_q0 <= g_prod[RECIP_SHIFT +: MDEG_W];
      g_nq <= f_nq;
    end
    if (h_adv) begin
      h_t  <= h_t_next;
      h_q0 <= g_q0;
      h_nq <= g_nq;
    end
    if (i_adv) begin
      i_bump <= (i_r_next[R_W-1:0] >= R_W'(pba_pkg::DIV_LO));
      i_q0   <= h_q0;
    end
    if (j_adv) begin
      j_mdeg <= j_mdeg_next;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // The larger magnitude must land exactly on the normalisation bit.
  `PBA_ASSERT(a_norm_pos, clk, rst,
              d2_vld && !(d2_data.side.dx_zero && d2_data.side.dy_zero)
              |-> ((d2_data.x | d2_data.y) >>> NORM_POS) == XY_W'(1),
              "normalised magnitude not at bit 59")
  // One correction step is enough only if the remainder stays below twice 15625.
  `PBA_ASSERT(a_div_rem, clk, rst,
              h_vld |-> i_r_next < pba_pkg::R_LIMIT,
              "reciprocal remainder out of range")
  // A bearing leaving the block is always below a full circle.
  `PBA_ASSERT(a_mdeg_range, clk, rst,
              j_vld |-> j_mdeg < pba_pkg::FULL_MDEG,
              "bearing not wrapped")
  // A stage that holds an item and is stalled keeps it for the next cycle.
  `PBA_ASSERT_NEXT(a_e_hold, clk, rst,
                   e_vld && !f_adv, e_vld && $stable(e_a),
                   "stalled stage lost its item")

endmodule

FILE: hw/rtl/pba_cordic.sv
// ----------------------------------------------------------------------------
// CORDIC vectoring pipeline
// One register stage per iteration; each stage rotates towards y = 0 and
// accumulates the angle. Stages advance independently, so bubbles close up.
// ----------------------------------------------------------------------------
module pba_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pba_pkg::cordic_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output pba_pkg::cordic_t out_data
);

  localparam int NSTEP  = pba_pkg::NSTEP;
  localparam int XY_W   = pba_pkg::XY_W;
  localparam int Z_W    = pba_pkg::Z_W;
  localparam int ATAN_W = pba_pkg::ATAN_W;

  logic [NSTEP-1:0] vld;
  logic [NSTEP:0]   adv;
  pba_pkg::cordic_t st [NSTEP];

  assign adv[NSTEP] = out_ready;

  for (genvar k = 0; k < NSTEP; k++) begin : g_stage
    pba_pkg::cordic_t       prev;
    pba_pkg::cordic_t       nxt;
    logic                   prev_vld;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  da;

    if (k == 0) begin : g_first
      assign prev     = in_data;
      assign prev_vld = in_valid;
    end else begin : g_rest
      assign prev     = st[k-1];
      assign prev_vld = vld[k-1];
    end

    assign adv[k] = !vld[k] || adv[k+1];
    assign xs = prev.x >>> k;
    assign ys = prev.y >>> k;
    assign da = $signed({{(Z_W - ATAN_W){1'b0}}, pba_pkg::ATAN_NDEG[k]});

    always_comb begin
      nxt.side = prev.side;
      if (!prev.y[XY_W-1]) begin
        nxt.x = prev.x + ys;
        nxt.y = prev.y - xs;
        nxt.z = prev.z + da;
      end else begin
        nxt.x = prev.x - ys;
        nxt.y = prev.y + xs;
        nxt.z = prev.z - da;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv[k]) begin
        vld[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        st[k] <= nxt;
      end
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld[NSTEP-1];
  assign out_data  = st[NSTEP-1];

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar bearing angle testbench
// Sends start and end point pairs into the stream input and checks every
// bearing that leaves the stream output. A table of directed pairs comes
// first, then a long random run. Each bearing is compared with a predictor
// built here, or with a value typed into the table where the answer is plain.
// ----------------------------------------------------------------------------
module tb;

  localparam int     CORDIC_STEPS   = pba_pkg::CORDIC_STEPS;
  localparam int     IN_TDATA_W     = pba_pkg::IN_TDATA_W;
  localparam int     OUT_TDATA_W    = pba_pkg::OUT_TDATA_W;
  localparam int     MDEG_W         = pba_pkg::MDEG_W;
  localparam int     NORM_POS       = pba_pkg::NORM_POS;

  // Angles in the predictor are held in units of 1e-9 degree.
  localparam longint NDEG_RIGHT     = 64'sd90000000000;
  localparam longint NDEG_HALF_TURN = 64'sd180000000000;
  localparam longint NDEG_FULL_TURN = 64'sd360000000000;
  localparam longint NDEG_PER_MDEG  = 64'sd1000000;
  localparam longint MDEG_FULL_TURN = 64'sd360000;
  localparam int     PIPE_STEPS     = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
  localparam int     PIPE_DEPTH     = CORDIC_STEPS + 12;

  // A table row with this in place of a bearing is checked by the predictor.
  localparam int     FROM_PREDICTOR = -1;

  localparam int     RANDOM_PAIRS   = 1700;

  // atan(2^-i) in 1e-9 degree, rounded to nearest.
  localparam longint ARCTAN_NDEG [32] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375,  64'sd1789910608,  64'sd895173710,   64'sd447614171,
    64'sd223810500,   64'sd111905677,   64'sd55952892,    64'sd27976453,
    64'sd13988227,    64'sd6994114,     64'sd3497057,     64'sd1748528,
    64'sd874264,      64'sd437132,      64'sd218566,      64'sd109283,
    64'sd54642,       64'sd27321,       64'sd13660,       64'sd6830,
    64'sd3415,        64'sd1708,        64'sd854,         64'sd427,
    64'sd213,         64'sd107,         64'sd53,          64'sd27
  };

  typedef struct {
    longint from_lon;
    longint from_lat;
    longint to_lon;
    longint to_lat;
    int     bearing;
  } pair_row_t;

  // Directed pairs. Bearings are typed in only where they are obvious: the
  // same point, the four axis directions, the coordinate extremes and the
  // near-north cases that round to a full circle or to zero.
  localparam int DIRECTED_ROWS = 22;
  pair_row_t directed_pairs [DIRECTED_ROWS] = '{
    '{0, 0, 0, 0, 0},
    '{-64'sd2147483648, -64'sd1073741824, -64'sd2147483648, -64'sd1073741824, 0},
    '{0, 0, 0, 1, 0},
    '{0, 0, 0, -1, 180000},
    '{0, 0, 1, 0, 90000},
    '{0, 0, -1, 0, 270000},
    '{-1800000000, 0, 1800000000, 0, 90000},
    '{1800000000, -900000000, 1800000000, 900000000, 0},
    '{-64'sd2147483648, 0, 2147483647, 0, 90000},
    '{2147483647, 0, -64'sd2147483648, 0, 270000},
    '{0, 1073741823, 0, -64'sd1073741824, 180000},
    '{2147483647, 1073741823, -64'sd2147483648, -64'sd1073741824, FROM_PREDICTOR},
    '{-64'sd2147483648, -64'sd1073741824, 2147483647, 1073741823, FROM_PREDICTOR},
    '{0, 0, 1000, 1000, FROM_PREDICTOR},
    '{0, 0, 1000, -1000, FROM_PREDICTOR},
    '{0, 0, -1000, -1000, FROM_PREDICTOR},
    '{0, 0, -1000, 1000, FROM_PREDICTOR},
    '{0, -900000000, -1, 900000000, 0},
    '{0, 900000000, 1, -900000000, 180000},
    '{0, 0, 1, 1073741823, 0},
    '{0, 0, 3, 4, FROM_PREDICTOR},
    '{5, 5, 123456789, -987654, FROM_PREDICTOR}
  };

  logic clk = 1'b0;
  logic rst;

  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // from_lon, from_lat, to_lon, to_lat, padding
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // bearing_mdeg, padding

  // Bearing typed into the table for the pair now on the input, if any.
  int                     pinned_mdeg;
  // While set, neither side idles.
  logic                   calm;

  logic [MDEG_W-1:0]      bearing_q [$];
  logic [MDEG_W-1:0]      want_mdeg;
  int                     mismatches;

  planar_bearing_angle dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bearing from the start to the end point packed in one input transaction.
  // The angle a = atan(dx/dy) comes from a 64-bit CORDIC vectoring pass over
  // the absolute differences, after both are scaled up until the larger one
  // reaches bit 59; it is then folded into the quadrant given by the signs.
  function automatic logic [MDEG_W-1:0] predict_bearing(logic [IN_TDATA_W-1:0] pair);
    longint          flon, flat, tlon, tlat, dlon, dlat;
    longint          x, y, xs, ys, ang, b, mdeg;
    longint unsigned dx, dy, big;
    flon = longint'($signed(pair[31:0]));
    flat = longint'($signed(pair[62:32]));
    tlon = longint'($signed(pair[94:63]));
    tlat = longint'($signed(pair[125:95]));
    dlon = tlon - flon;
    dlat = tlat - flat;
    dx   = (dlon < 0) ? -dlon : dlon;
    dy   = (dlat < 0) ? -dlat : dlat;
    ang  = 0;
    if (dx == 0) begin
      ang = 0;
    end else if (dy == 0) begin
      ang = NDEG_RIGHT;
    end else begin
      big = (dx > dy) ? dx : dy;
      while (big < (64'd1 << NORM_POS)) begin
        big = big << 1;
        dx  = dx << 1;
        dy  = dy << 1;
      end
      x = dy;
      y = dx;
      for (int i = 0; i < PIPE_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x   = x + ys;
          y   = y - xs;
          ang = ang + ARCTAN_NDEG[i];
        end else begin
          x   = x - ys;
          y   = y + xs;
          ang = ang - ARCTAN_NDEG[i];
        end
      end
      if (ang < 0) ang = 0;
      if (ang > NDEG_RIGHT) ang = NDEG_RIGHT;
    end
    // East and north are taken with equality, so a pure north pair is 0.
    if (tlon >= flon) b = (tlat >= flat) ? ang : NDEG_HALF_TURN - ang;
    else              b = (tlat >= flat) ? NDEG_FULL_TURN - ang : NDEG_HALF_TURN + ang;
    mdeg = (b + NDEG_PER_MDEG / 2) / NDEG_PER_MDEG;
    if (mdeg >= MDEG_FULL_TURN) mdeg = 0;
    return MDEG_W'(mdeg);
  endfunction

  // Offers one point pair and returns at the falling edge after acceptance.
  // It is entered at a falling edge.
  task automatic offer_pair(input longint flo, input longint fla, input longint tlo,
                            input longint tla, input int pin);
    while (!calm && $urandom_range(0, 99) < 11) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= {2'b00, tla[30:0], tlo[31:0], fla[30:0], flo[31:0]};
    pinned_mdeg <= pin;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic longint any_lon();
    return longint'($urandom_range(0, 32'd3600000000)) - 64'sd1800000000;
  endfunction

  function automatic longint any_lat();
    return longint'($urandom_range(0, 32'd1800000000)) - 64'sd900000000;
  endfunction

  // A small signed offset of random magnitude, to put the two points close.
  function automatic longint nudge();
    longint span;
    span = longint'(1) << $urandom_range(0, 20);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  // Receiver side: stalls at random with odds of about 11 percent, except while calm.
  always @(negedge clk) begin
    m_tready <= !rst && (calm || $urandom_range(0, 99) >= 11);
  end

  // Every accepted input transaction queues the bearing it must produce, and
  // every accepted output transaction is checked against the oldest one.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      if (pinned_mdeg != FROM_PREDICTOR) bearing_q.push_back(MDEG_W'(pinned_mdeg));
      else bearing_q.push_back(predict_bearing(s_tdata));
    end
    if (!rst && m_tvalid && m_tready) begin
      if (bearing_q.size() == 0) begin
        $display("%0t: unexpected bearing: expected none, got %0d", $time, m_tdata);
        mismatches++;
      end else begin
        want_mdeg = bearing_q.pop_front();
        if (m_tdata !== OUT_TDATA_W'(want_mdeg)) begin
          $display("%0t: bearing mismatch: expected %0d, got %0d",
                   $time, want_mdeg, m_tdata);
          mismatches++;
        end
      end
    end
  end

  initial begin
    longint flo, fla, tlo, tla;
    int     kind;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    pinned_mdeg = FROM_PREDICTOR;
    calm        = 1'b0;
    mismatches  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_pairs[r]) begin
      offer_pair(directed_pairs[r].from_lon, directed_pairs[r].from_lat,
                 directed_pairs[r].to_lon, directed_pairs[r].to_lat,
                 directed_pairs[r].bearing);
    end

    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      // A stretch in the middle runs with both sides flowing freely.
      calm = (n >= 300 && n < 550);
      // Once, the sender holds off until the pipeline has drained.
      if (n == 900) begin
        s_tvalid <= 1'b0;
        while (bearing_q.size() != 0) @(negedge clk);
      end
      kind = $urandom_range(0, 99);
      flo  = any_lon();
      fla  = any_lat();
      if (kind < 50) begin
        tlo = any_lon();
        tla = any_lat();
      end else if (kind < 72) begin
        tlo = flo + nudge();
        tla = fla + nudge();
      end else if (kind < 80) begin
        tlo = flo;
        tla = ($urandom_range(0, 1) != 0) ? any_lat() : fla + nudge();
      end else if (kind < 88) begin
        tla = fla;
        tlo = ($urandom_range(0, 1) != 0) ? any_lon() : flo + nudge();
      end else begin
        // Raw bit patterns, which may lie outside the coordinate ranges.
        flo = longint'($urandom);
        fla = longint'($urandom);
        tlo = longint'($urandom);
        tla = longint'($urandom);
      end
      offer_pair(flo, fla, tlo, tla, FROM_PREDICTOR);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    while (bearing_q.size() != 0) @(negedge clk);
    // Anything still inside the pipeline would surface within its depth.
    repeat (PIPE_DEPTH + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("timeout with %0d bearings outstanding", bearing_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
